// File: rtl/core/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Shared widths, constants and stage payload types of the RGB-to-HSV pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Scale of the hue: a full turn is 2^HUE_BITS.
  localparam int unsigned HUE_BITS   = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned HUE_W      = 16;

  // The hue numerator lies below 6 * 255, so it fits in CH_W + 3 bits.
  localparam int unsigned NUM_W      = CH_W + 3;

  // The hue reciprocal is floor(2^RECH_SHIFT / (6 * delta)). It stays below
  // 2^(RECH_SHIFT - 2) because the divisor is at least six.
  localparam int unsigned RECH_SHIFT = HUE_BITS + NUM_W;
  localparam int unsigned RECH_W     = RECH_SHIFT - 2;
  localparam int unsigned PRODH_W    = RECH_W + NUM_W;
  localparam int unsigned REMH_W     = HUE_BITS + NUM_W;

  // The saturation reciprocal is floor(2^RECS_SHIFT / max), up to 2^RECS_SHIFT.
  localparam int unsigned RECS_SHIFT = 2 * CH_W;
  localparam int unsigned RECS_W     = RECS_SHIFT + 1;
  localparam int unsigned NS_W       = 2 * CH_W;
  localparam int unsigned PRODS_W    = NS_W + RECS_W;

  localparam int unsigned TBL_DEPTH  = 1 << CH_W;

  // Stage 1: extremes and the wrapped hue numerator.
  typedef struct packed {
    logic [CH_W-1:0]  mx;
    logic [CH_W-1:0]  delta;
    logic [NUM_W-1:0] num;
  } rth_s1_t;

  // Stage 2: divisors, dividends and reciprocals.
  typedef struct packed {
    logic              grey;
    logic [CH_W-1:0]   mx;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  d6;
    logic [NS_W-1:0]   ns;
    logic [RECH_W-1:0] rech;
    logic [RECS_W-1:0] recs;
  } rth_s2_t;

  // Stage 3: products with the reciprocals.
  typedef struct packed {
    logic               grey;
    logic [CH_W-1:0]    mx;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   d6;
    logic [NS_W-1:0]    ns;
    logic [PRODH_W-1:0] prodh;
    logic [PRODS_W-1:0] prods;
  } rth_s3_t;

  // Stage 4: quotient estimates and their back products.
  typedef struct packed {
    logic                grey;
    logic [CH_W-1:0]     mx;
    logic [NUM_W-1:0]    num;
    logic [NUM_W-1:0]    d6;
    logic [NS_W-1:0]     ns;
    logic [HUE_BITS-1:0] qh;
    logic [CH_W-1:0]     qs;
    logic [REMH_W-1:0]   backh;
    logic [NS_W-1:0]     backs;
  } rth_s4_t;

endpackage

// File: rtl/core/rth_pix_if.sv
// ----------------------------------------------------------------------------
// rth_pix_if
// Pixel channel: one RGB word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rth_pix_if import rth_pkg::*; ();

  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// File: rtl/core/rth_hsv_if.sv
// ----------------------------------------------------------------------------
// rth_hsv_if
// Result channel: one HSV word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rth_hsv_if import rth_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);

endinterface

// File: rtl/core/rth_front.sv
// ----------------------------------------------------------------------------
// rth_front
// First stage: maximum, minimum, delta and the hue numerator wrapped into
// the range zero to six times delta.
// ----------------------------------------------------------------------------
module rth_front import rth_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [CH_W-1:0] red_i,
  input  logic [CH_W-1:0] green_i,
  input  logic [CH_W-1:0] blue_i,
  output logic            ready_o,
  output logic            valid_o,
  output rth_s1_t         s1_o,
  input  logic            ready_i
);

  localparam int unsigned SW = NUM_W + 1;

  logic            r_max;
  logic            g_max;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] delta;
  logic [SW-1:0]   d_x;
  logic [SW-1:0]   r_x;
  logic [SW-1:0]   g_x;
  logic [SW-1:0]   b_x;
  logic [SW-1:0]   num;
  logic [SW-1:0]   num_wrap;
  rth_s1_t         s1_d;
  rth_s1_t         s1_q;
  logic            valid_q;
  logic            en;

  always_comb begin
    // Ties go to red, then green, then blue.
    r_max = (red_i >= green_i) && (red_i >= blue_i);
    g_max = !r_max && (green_i >= blue_i);
    mx    = r_max ? red_i : (g_max ? green_i : blue_i);
    if ((red_i <= green_i) && (red_i <= blue_i)) begin
      mn = red_i;
    end else if (green_i <= blue_i) begin
      mn = green_i;
    end else begin
      mn = blue_i;
    end
    delta = mx - mn;

    d_x = SW'(delta);
    r_x = SW'(red_i);
    g_x = SW'(green_i);
    b_x = SW'(blue_i);
    priority if (r_max) begin
      num = g_x - b_x;
    end else if (g_max) begin
      num = (d_x << 1) + b_x - r_x;
    end else begin
      num = (d_x << 2) + r_x - g_x;
    end
    // A negative numerator wraps by one full turn, six times delta.
    num_wrap = num[SW-1] ? num + (d_x << 2) + (d_x << 1) : num;

    s1_d.mx    = mx;
    s1_d.delta = delta;
    s1_d.num   = num_wrap[NUM_W-1:0];
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign s1_o    = s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      s1_q <= s1_d;
    end
  end

endmodule

// File: rtl/core/rth_recip.sv
// ----------------------------------------------------------------------------
// rth_recip
// Second stage: reciprocal lookups for both divisions, the hue divisor
// six times delta, and the saturation dividend 255 times delta.
// ----------------------------------------------------------------------------
module rth_recip import rth_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  rth_s1_t s1_i,
  output logic    ready_o,
  output logic    valid_o,
  output rth_s2_t s2_o,
  input  logic    ready_i
);

  logic [RECH_W-1:0] rech_tbl [TBL_DEPTH];
  logic [RECS_W-1:0] recs_tbl [TBL_DEPTH];
  rth_s2_t           s2_d;
  rth_s2_t           s2_q;
  logic              valid_q;
  logic              en;

  // Reciprocals are rounded down, so a quotient estimate is never too high
  // and at most one below the true quotient. Entry zero is never used.
  for (genvar i = 0; i < TBL_DEPTH; i++) begin : g_tbl
    localparam logic [63:0] HDiv = (i == 0) ? 64'd1 : 64'd6 * 64'(i);
    localparam logic [63:0] SDiv = (i == 0) ? 64'd1 : 64'(i);
    localparam logic [63:0] HRec = (i == 0) ? 64'd0 : (64'd1 << RECH_SHIFT) / HDiv;
    localparam logic [63:0] SRec = (i == 0) ? 64'd0 : (64'd1 << RECS_SHIFT) / SDiv;
    assign rech_tbl[i] = HRec[RECH_W-1:0];
    assign recs_tbl[i] = SRec[RECS_W-1:0];
  end

  always_comb begin
    s2_d.grey = (s1_i.delta == '0);
    s2_d.mx   = s1_i.mx;
    s2_d.num  = s1_i.num;
    s2_d.d6   = (NUM_W'(s1_i.delta) << 2) + (NUM_W'(s1_i.delta) << 1);
    s2_d.ns   = {s1_i.delta, CH_W'(0)} - NS_W'(s1_i.delta);
    s2_d.rech = rech_tbl[s1_i.delta];
    s2_d.recs = recs_tbl[s1_i.mx];
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_o = valid_q;
  assign s2_o    = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      s2_q <= s2_d;
    end
  end

endmodule

// File: rtl/core/rth_div.sv
// ----------------------------------------------------------------------------
// rth_div
// Stages three to five: reciprocal multiply, back multiply and a single
// remainder correction for the hue and saturation quotients. The last stage
// is the output register.
// ----------------------------------------------------------------------------
module rth_div import rth_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  rth_s2_t          s2_i,
  output logic             ready_o,
  output logic             valid_o,
  output logic [HUE_W-1:0] hue_o,
  output logic [CH_W-1:0]  sat_o,
  output logic [CH_W-1:0]  val_o,
  input  logic             ready_i
);

  rth_s3_t             s3_d;
  rth_s3_t             s3_q;
  rth_s4_t             s4_d;
  rth_s4_t             s4_q;
  logic                v3_q;
  logic                v4_q;
  logic                v5_q;
  logic                en3;
  logic                en4;
  logic                en5;
  logic [REMH_W-1:0]   remh;
  logic [NS_W-1:0]     rems;
  logic [HUE_BITS-1:0] hue_full;
  logic [CH_W-1:0]     sat_d;
  logic [HUE_W-1:0]    hue_q;
  logic [CH_W-1:0]     sat_q;
  logic [CH_W-1:0]     val_q;

  // Stage three: dividend times reciprocal.
  always_comb begin
    s3_d.grey  = s2_i.grey;
    s3_d.mx    = s2_i.mx;
    s3_d.num   = s2_i.num;
    s3_d.d6    = s2_i.d6;
    s3_d.ns    = s2_i.ns;
    s3_d.prodh = PRODH_W'(s2_i.num) * PRODH_W'(s2_i.rech);
    s3_d.prods = PRODS_W'(s2_i.ns) * PRODS_W'(s2_i.recs);
  end

  // Stage four: quotient estimates and estimate times divisor.
  always_comb begin
    s4_d.grey  = s3_q.grey;
    s4_d.mx    = s3_q.mx;
    s4_d.num   = s3_q.num;
    s4_d.d6    = s3_q.d6;
    s4_d.ns    = s3_q.ns;
    s4_d.qh    = s3_q.prodh[NUM_W +: HUE_BITS];
    s4_d.qs    = s3_q.prods[RECS_SHIFT +: CH_W];
    s4_d.backh = REMH_W'(s3_q.prodh[NUM_W +: HUE_BITS]) * REMH_W'(s3_q.d6);
    s4_d.backs = NS_W'(s3_q.prods[RECS_SHIFT +: CH_W]) * NS_W'(s3_q.mx);
  end

  // Stage five: an estimate one short leaves a remainder of at least the
  // divisor, which bumps the quotient by one.
  always_comb begin
    remh = {s4_q.num, HUE_BITS'(0)} - s4_q.backh;
    rems = s4_q.ns - s4_q.backs;
    if (s4_q.grey) begin
      hue_full = '0;
      sat_d    = '0;
    end else begin
      hue_full = (remh >= REMH_W'(s4_q.d6)) ? s4_q.qh + HUE_BITS'(1) : s4_q.qh;
      sat_d    = (rems >= NS_W'(s4_q.mx)) ? s4_q.qs + CH_W'(1) : s4_q.qs;
    end
  end

  assign en5     = !v5_q || ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign ready_o = en3;
  assign valid_o = v5_q;
  assign hue_o   = hue_q;
  assign sat_o   = sat_q;
  assign val_o   = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      s3_q <= s3_d;
    end
    if (en4 && v3_q) begin
      s4_q <= s4_d;
    end
    if (en5 && v4_q) begin
      hue_q <= HUE_W'(hue_full);
      sat_q <= sat_d;
      val_q <= s4_q.mx;
    end
  end

endmodule

// File: rtl/core/rgb_to_hsv.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv
// Pixel converter from 8-bit RGB to hue, saturation and brightness, built as
// a five-stage pipeline with reciprocal-table division.
// ----------------------------------------------------------------------------
//   Channel  Direction  Word                            Handshake
//   pix_i    in         red, green, blue (8 bits each)  valid/ready
//   hsv_o    out        hue (16), saturation (8),       valid/ready
//                       brightness (8)
//
// One pixel enters per clock while the result side takes its words; a pixel
// passes in turn through the five register stages: extremes, table lookup,
// two multiply stages and the correction stage of the dividers. Each stage
// holds its word while the next one is full and stalled, so empty stages
// keep filling during a stall and no word is dropped or repeated. Reset
// clears only the stage valid bits.
// ----------------------------------------------------------------------------
module rgb_to_hsv import rth_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rth_pix_if.sink   pix_i,
  rth_hsv_if.source hsv_o
);

  logic    v1;
  logic    v2;
  logic    rdy1;
  logic    rdy2;
  rth_s1_t s1;
  rth_s2_t s2;

  rth_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_i.valid),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .ready_o (pix_i.ready),
    .valid_o (v1),
    .s1_o    (s1),
    .ready_i (rdy1)
  );

  rth_recip u_recip (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .s1_i    (s1),
    .ready_o (rdy1),
    .valid_o (v2),
    .s2_o    (s2),
    .ready_i (rdy2)
  );

  rth_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .s2_i    (s2),
    .ready_o (rdy2),
    .valid_o (hsv_o.valid),
    .hue_o   (hsv_o.hue),
    .sat_o   (hsv_o.saturation),
    .val_o   (hsv_o.brightness),
    .ready_i (hsv_o.ready)
  );

endmodule

// File: rtl/core/rth_checker.sv
// ----------------------------------------------------------------------------
// rth_checker
// Port-level checks of the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rth_checker import rth_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [HUE_W-1:0] hue_i,
  input logic [CH_W-1:0]  sat_i,
  input logic [CH_W-1:0]  val_i
);

  // A result word that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result word dropped while stalled");

  // A sink that takes results lets the pipeline take a new pixel.
  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_i)
    else $error("pixel refused while the result side is ready");

  // Any colored pixel has a saturation of at least one, so zero saturation
  // means grey, which must carry a zero hue.
  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (sat_i == '0) |-> (hue_i == '0))
    else $error("grey result with a nonzero hue");

  // Black has no hue and no saturation.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (val_i == '0) |-> (sat_i == '0) && (hue_i == '0))
    else $error("black result with nonzero hue or saturation");

  // Nothing is offered right out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered right after reset");

endmodule

bind rgb_to_hsv rth_checker u_rth_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (hsv_o.valid),
  .out_ready_i (hsv_o.ready),
  .hue_i       (hsv_o.hue),
  .sat_i       (hsv_o.saturation),
  .val_i       (hsv_o.brightness)
);
